[hdl/pcbp_pkg.sv]
// shared types and constants of the prefix code bit packer
package pcbp_pkg;

   // field widths
   localparam int CMD_W = 2;
   localparam int SYM_W = 8;
   localparam int CODE_W = 32;
   localparam int LEN_W = 6;
   localparam int DATA_W = 16;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 3;
   localparam int TREE_W = 13;
   localparam int PAD_W = 3;

   // code table and accumulator sizing
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ACC_W = CODE_W + BYTE_W;
   localparam int MAX_RESULTS = 4;
   localparam int CNT_W = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

   // result kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_HEADER = 1'b1;

   // register map
   localparam int ADDR_W = 2;
   localparam int PDATA_W = 32;
   localparam logic [ADDR_W-1:0] REG_TREE_SIZE = 2'd0;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0] code_len;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic kind;
      logic last;
   } rsp_item_type;

   // request held in the input register, handed to the packer
   typedef struct packed {
      logic valid;
      logic [CMD_W-1:0] cmd;
      logic sym_nonzero;
   } stage_type;

endpackage

[hdl/pcbp_code_table.sv]
// code and length table with registered read
module pcbp_code_table (
   input  logic clock,
   input  logic wr_en,
   input  logic [pcbp_pkg::SYM_W-1:0] wr_addr,
   input  logic [pcbp_pkg::CODE_W-1:0] wr_code,
   input  logic [pcbp_pkg::LEN_W-1:0] wr_len,
   input  logic rd_en,
   input  logic [pcbp_pkg::SYM_W-1:0] rd_addr,
   output logic [pcbp_pkg::CODE_W-1:0] rd_code,
   output logic [pcbp_pkg::LEN_W-1:0] rd_len
);

   logic [pcbp_pkg::CODE_W+pcbp_pkg::LEN_W-1:0] mem [pcbp_pkg::TABLE_DEPTH];
   logic [pcbp_pkg::CODE_W+pcbp_pkg::LEN_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_code, wr_len};
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_code = rd_data_ff[pcbp_pkg::CODE_W+pcbp_pkg::LEN_W-1:pcbp_pkg::LEN_W];
   assign rd_len = rd_data_ff[pcbp_pkg::LEN_W-1:0];

endmodule

[hdl/pcbp_packer.sv]
// bit accumulator, byte splitting and result output register
module pcbp_packer (
   input  logic clock,
   input  logic reset,
   input  pcbp_pkg::stage_type stage,
   input  logic [pcbp_pkg::CODE_W-1:0] code,
   input  logic [pcbp_pkg::LEN_W-1:0] len,
   input  logic [pcbp_pkg::TREE_W-1:0] tree_size,
   output logic take,
   output logic rsp_valid,
   input  logic rsp_stall,
   output pcbp_pkg::rsp_item_type rsp_item
);

   logic [pcbp_pkg::BYTE_W-1:0] partial_ff, partial_in;
   logic [pcbp_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [pcbp_pkg::DATA_W-1:0] grp_data_ff [pcbp_pkg::MAX_RESULTS];
   logic [pcbp_pkg::DATA_W-1:0] grp_data_in [pcbp_pkg::MAX_RESULTS];
   logic [pcbp_pkg::MAX_RESULTS-1:0] grp_kind_ff, grp_kind_in;
   logic [pcbp_pkg::CNT_W-1:0] grp_cnt_ff, grp_cnt_in;

   logic [pcbp_pkg::CODE_W-1:0] code_left;
   logic [pcbp_pkg::ACC_W-1:0] acc;
   logic [pcbp_pkg::LEN_W-1:0] total;
   logic [pcbp_pkg::CNT_W-1:0] nbytes;
   logic [pcbp_pkg::CNT_W-1:0] n_res;
   logic [pcbp_pkg::DATA_W-1:0] res_data [pcbp_pkg::MAX_RESULTS];
   logic [pcbp_pkg::MAX_RESULTS-1:0] res_kind;
   logic [pcbp_pkg::PAD_W-1:0] pad;
   logic [pcbp_pkg::BYTE_W-1:0] rest_byte;
   logic rsp_take;
   logic grp_free;
   logic do_encode;
   logic do_flush;

   // append the code after the bits already gathered
   always_comb begin
      code_left = code << (pcbp_pkg::LEN_W'(pcbp_pkg::CODE_W) - len);
      acc = {partial_ff, pcbp_pkg::CODE_W'(0)}
         | ({code_left, pcbp_pkg::BYTE_W'(0)} >> fill_ff);
      total = pcbp_pkg::LEN_W'(fill_ff) + len;
      nbytes = total[pcbp_pkg::LEN_W-1:pcbp_pkg::FILL_W];
      rest_byte = acc[(pcbp_pkg::ACC_W - 1) - pcbp_pkg::BYTE_W * int'(nbytes) -: pcbp_pkg::BYTE_W];
      pad = pcbp_pkg::PAD_W'(4'd8 - {1'b0, fill_ff});
   end

   // results and next accumulator for the request in the input register
   always_comb begin
      do_encode = stage.valid && (stage.cmd == pcbp_pkg::CMD_ENCODE) && stage.sym_nonzero;
      do_flush = stage.valid && (stage.cmd == pcbp_pkg::CMD_FLUSH);
      n_res = '0;
      res_kind = '0;
      partial_in = partial_ff;
      fill_in = fill_ff;
      for (int i = 0; i < pcbp_pkg::MAX_RESULTS; i++) begin
         res_data[i] = {pcbp_pkg::BYTE_W'(0),
            acc[(pcbp_pkg::ACC_W - 1) - pcbp_pkg::BYTE_W * i -: pcbp_pkg::BYTE_W]};
      end
      if (do_encode) begin
         n_res = nbytes;
         partial_in = rest_byte;
         fill_in = total[pcbp_pkg::FILL_W-1:0];
      end else if (do_flush) begin
         partial_in = '0;
         fill_in = '0;
         if (fill_ff != '0) begin
            n_res = pcbp_pkg::CNT_W'(2);
            res_data[0] = {pcbp_pkg::BYTE_W'(0), partial_ff};
            res_data[1] = {pad, tree_size};
            res_kind[1] = pcbp_pkg::KIND_HEADER;
         end else begin
            n_res = pcbp_pkg::CNT_W'(1);
            res_data[0] = {pcbp_pkg::PAD_W'(0), tree_size};
            res_kind[0] = pcbp_pkg::KIND_HEADER;
         end
      end
   end

   // hand-off between the input register and the output group
   assign rsp_valid = (grp_cnt_ff != '0);
   assign rsp_take = rsp_valid && !rsp_stall;
   assign grp_free = (grp_cnt_ff == '0) || ((grp_cnt_ff == pcbp_pkg::CNT_W'(1)) && rsp_take);
   assign take = stage.valid && ((n_res == '0) || grp_free);

   // output group next value: load a new group or shift out one word
   always_comb begin
      grp_cnt_in = grp_cnt_ff;
      grp_kind_in = grp_kind_ff;
      for (int i = 0; i < pcbp_pkg::MAX_RESULTS; i++) begin
         grp_data_in[i] = grp_data_ff[i];
      end
      if (take && (n_res != '0)) begin
         grp_cnt_in = n_res;
         grp_kind_in = res_kind;
         for (int i = 0; i < pcbp_pkg::MAX_RESULTS; i++) begin
            grp_data_in[i] = res_data[i];
         end
      end else if (rsp_take) begin
         grp_cnt_in = grp_cnt_ff - pcbp_pkg::CNT_W'(1);
         grp_kind_in = grp_kind_ff >> 1;
         for (int i = 0; i < pcbp_pkg::MAX_RESULTS - 1; i++) begin
            grp_data_in[i] = grp_data_ff[i+1];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff <= '0;
         grp_cnt_ff <= '0;
      end else begin
         grp_cnt_ff <= grp_cnt_in;
         if (take) begin
            partial_ff <= partial_in;
            fill_ff <= fill_in;
         end
      end
   end

   // output words
   always_ff @(posedge clock) begin
      grp_kind_ff <= grp_kind_in;
      for (int i = 0; i < pcbp_pkg::MAX_RESULTS; i++) begin
         grp_data_ff[i] <= grp_data_in[i];
      end
   end

   assign rsp_item.data = grp_data_ff[0];
   assign rsp_item.kind = grp_kind_ff[0];
   assign rsp_item.last = (grp_cnt_ff == pcbp_pkg::CNT_W'(1));

`ifndef NO_ASSERTIONS
   // the group never holds more words than one request can make
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      grp_cnt_ff <= pcbp_pkg::CNT_W'(pcbp_pkg::MAX_RESULTS))
      else $error("output group count out of range");

   // a header word always closes its request
   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind |-> rsp_item.last)
      else $error("header word not marked last");

   // unfilled accumulator bits stay zero
   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      (partial_ff << fill_ff) == '0)
      else $error("stray bits below the fill point");

   // a flush empties the accumulator
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      take && do_flush |=> (fill_ff == '0) && (partial_ff == '0))
      else $error("accumulator not cleared by flush");
`endif

endmodule

[hdl/prefix_code_bit_packer.sv]
// Prefix code bit packer: load requests fill a 256-entry code table, encode
// requests for a nonzero symbol append its code to a byte accumulator (first
// bit at the top) and emit each completed byte, flush requests emit the
// zero-padded partial byte, if any, and a header word {pad count, tree_size}.
// A request enters the input register while the table is read, and is resolved
// there once the output group can take its results, which are then registered
// in the output group register. Requests with no result go at one per cycle. A
// request with n results holds the output group register until its n words have
// left, one word per cycle while rsp_stall is low, so the output channel sets
// the sustained rate, up to 4 words for a long code. The code table needs no
// clearing after reset; entries never loaded read back as whatever the memory holds.
module prefix_code_bit_packer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  pcbp_pkg::req_item_type req_item,
   output logic rsp_valid,
   input  logic rsp_stall,
   output pcbp_pkg::rsp_item_type rsp_item,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [pcbp_pkg::ADDR_W-1:0] paddr,
   input  logic [pcbp_pkg::PDATA_W-1:0] pwdata,
   output logic [pcbp_pkg::PDATA_W-1:0] prdata,
   output logic pready
);

   logic [pcbp_pkg::TREE_W-1:0] tree_size_ff;
   logic a_valid_ff;
   logic [pcbp_pkg::CMD_W-1:0] a_cmd_ff;
   logic a_sym_nz_ff;
   pcbp_pkg::stage_type stage;
   logic accept;
   logic take;
   logic load_en;
   logic [pcbp_pkg::LEN_W-1:0] load_len;
   logic [pcbp_pkg::CODE_W-1:0] rd_code;
   logic [pcbp_pkg::LEN_W-1:0] rd_len;

   // register port
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tree_size_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr == pcbp_pkg::REG_TREE_SIZE)) begin
         tree_size_ff <= pwdata[pcbp_pkg::TREE_W-1:0];
      end
   end
   assign prdata = (paddr == pcbp_pkg::REG_TREE_SIZE)
      ? {(pcbp_pkg::PDATA_W - pcbp_pkg::TREE_W)'(0), tree_size_ff} : '0;

   // request handshake
   assign req_stall = a_valid_ff && !take;
   assign accept = req_valid && !req_stall;

   // length saturation on load
   assign load_en = accept && (req_item.cmd == pcbp_pkg::CMD_LOAD);
   assign load_len = (req_item.code_len > pcbp_pkg::LEN_W'(pcbp_pkg::LEN_LIMIT))
      ? pcbp_pkg::LEN_W'(pcbp_pkg::LEN_LIMIT) : req_item.code_len;

   pcbp_code_table u_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (req_item.symbol),
      .wr_code (req_item.code_bits),
      .wr_len  (load_len),
      .rd_en   (accept && (req_item.cmd == pcbp_pkg::CMD_ENCODE)),
      .rd_addr (req_item.symbol),
      .rd_code (rd_code),
      .rd_len  (rd_len)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (take) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff <= req_item.cmd;
         a_sym_nz_ff <= (req_item.symbol != '0);
      end
   end

   assign stage.valid = a_valid_ff;
   assign stage.cmd = a_cmd_ff;
   assign stage.sym_nonzero = a_sym_nz_ff;

   pcbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .code      (rd_code),
      .len       (rd_len),
      .tree_size (tree_size_ff),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
